// ===== rtl/frustum_culling_tester_macros.svh =====
// Assertion macros for the frustum culling tester.
// Included by the top level; no other dependencies.
`ifndef FRUSTUM_CULLING_TESTER_MACROS_SVH
`define FRUSTUM_CULLING_TESTER_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define FCT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/fct_pkg.sv =====
// Shared types and constants for the frustum culling tester.
// No dependencies.
`timescale 1ns / 1ps

package fct_pkg;

	localparam int COORD_W  = 32;
	localparam int CORNER_W = COORD_W + 1;
	localparam int PROD_W   = COORD_W + CORNER_W;
	localparam int FRAC_W   = 16;
	localparam int SUM_W    = PROD_W + 3;

	localparam logic [2:0] CMD_LOAD   = 3'd0;
	localparam logic [2:0] CMD_POINT  = 3'd1;
	localparam logic [2:0] CMD_SPHERE = 3'd2;
	localparam logic [2:0] CMD_CUBE   = 3'd3;
	localparam logic [2:0] CMD_BOX    = 3'd4;

	localparam logic [1:0] V_OUTSIDE  = 2'd0;
	localparam logic [1:0] V_STRADDLE = 2'd1;
	localparam logic [1:0] V_INSIDE   = 2'd2;

	typedef struct packed {
		logic [2:0]                cmd;
		logic [2:0]                plane_index;
		logic signed [COORD_W-1:0] coef_a;
		logic signed [COORD_W-1:0] coef_b;
		logic signed [COORD_W-1:0] coef_c;
		logic signed [COORD_W-1:0] coef_d;
		logic signed [COORD_W-1:0] near_x;
		logic signed [COORD_W-1:0] near_y;
		logic signed [COORD_W-1:0] near_z;
		logic signed [COORD_W-1:0] far_x_or_extent;
		logic signed [COORD_W-1:0] far_y;
		logic signed [COORD_W-1:0] far_z;
	} query_t;

	typedef struct packed {
		logic [1:0] verdict;
		logic [2:0] query_kind;
	} result_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] a;
		logic signed [COORD_W-1:0] b;
		logic signed [COORD_W-1:0] c;
		logic signed [COORD_W-1:0] d;
	} plane_t;

	// Low and high coordinate per axis, plus the sphere radius (zero otherwise).
	typedef struct packed {
		logic signed [CORNER_W-1:0] x0;
		logic signed [CORNER_W-1:0] x1;
		logic signed [CORNER_W-1:0] y0;
		logic signed [CORNER_W-1:0] y1;
		logic signed [CORNER_W-1:0] z0;
		logic signed [CORNER_W-1:0] z1;
		logic signed [COORD_W-1:0]  radd;
	} corners_t;

	typedef struct packed {
		logic out_le;
		logic out_lt;
		logic min_lt;
	} plane_flags_t;

endpackage

// ===== rtl/fct_plane_store.sv =====
// Plane equation registers, written one plane per load transaction.
// Depends on fct_pkg.
`timescale 1ns / 1ps

module fct_plane_store #(
	parameter int PLANE_COUNT = 6
) (
	input  logic            clk,
	input  logic            we,
	input  logic [2:0]      idx,
	input  fct_pkg::plane_t wdata,
	output fct_pkg::plane_t planes [PLANE_COUNT]
);
	import fct_pkg::*;

	plane_t plane_q [PLANE_COUNT];

	for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
		always_ff @(posedge clk) begin
			if (we && (32'(idx) == 32'(p))) begin
				plane_q[p] <= wdata;
			end
		end
		assign planes[p] = plane_q[p];
	end

endmodule

// ===== rtl/fct_plane_eval.sv =====
// Three-stage evaluation of one plane: products, per-axis min/max, sums and signs.
// Depends on fct_pkg.
`timescale 1ns / 1ps

module fct_plane_eval (
	input  logic                  clk,
	input  logic                  en,
	input  fct_pkg::plane_t       plane,
	input  fct_pkg::corners_t     crn,
	output fct_pkg::plane_flags_t flags
);
	import fct_pkg::*;

	logic signed [PROD_W-1:0]   ax0_s2, ax1_s2, by0_s2, by1_s2, cz0_s2, cz1_s2;
	logic signed [CORNER_W-1:0] dr_s2;
	logic signed [PROD_W-1:0]   amax_s3, amin_s3, bmax_s3, bmin_s3, cmax_s3, cmin_s3;
	logic signed [CORNER_W-1:0] dr_s3;
	plane_flags_t               flags_s4;
	logic signed [SUM_W-1:0]    dterm, sum_hi, sum_lo;

	always_ff @(posedge clk) begin
		if (en) begin
			ax0_s2 <= plane.a * crn.x0;
			ax1_s2 <= plane.a * crn.x1;
			by0_s2 <= plane.b * crn.y0;
			by1_s2 <= plane.b * crn.y1;
			cz0_s2 <= plane.c * crn.z0;
			cz1_s2 <= plane.c * crn.z1;
			dr_s2  <= CORNER_W'(plane.d) + CORNER_W'(crn.radd);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			amax_s3 <= (ax0_s2 > ax1_s2) ? ax0_s2 : ax1_s2;
			amin_s3 <= (ax0_s2 > ax1_s2) ? ax1_s2 : ax0_s2;
			bmax_s3 <= (by0_s2 > by1_s2) ? by0_s2 : by1_s2;
			bmin_s3 <= (by0_s2 > by1_s2) ? by1_s2 : by0_s2;
			cmax_s3 <= (cz0_s2 > cz1_s2) ? cz0_s2 : cz1_s2;
			cmin_s3 <= (cz0_s2 > cz1_s2) ? cz1_s2 : cz0_s2;
			dr_s3   <= dr_s2;
		end
	end

	always_comb begin
		dterm  = SUM_W'($signed({dr_s3, {FRAC_W{1'b0}}}));
		sum_hi = SUM_W'(amax_s3) + SUM_W'(bmax_s3) + SUM_W'(cmax_s3) + dterm;
		sum_lo = SUM_W'(amin_s3) + SUM_W'(bmin_s3) + SUM_W'(cmin_s3) + dterm;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s4.out_lt <= sum_hi[SUM_W-1];
			flags_s4.out_le <= sum_hi[SUM_W-1] || (sum_hi == '0);
			flags_s4.min_lt <= sum_lo[SUM_W-1];
		end
	end

	assign flags = flags_s4;

endmodule

// ===== rtl/frustum_culling_tester.sv =====
// Top level of the frustum culling tester: input staging, plane lanes, verdict.
// Depends on fct_pkg, fct_plane_store, fct_plane_eval and the macros header.
//
//   channel  | signals                              | moves
//   ---------+--------------------------------------+------------------------------
//   query    | query_valid, query_ready, query      | plane loads and test queries
//   result   | result_valid, result_ready, result   | one verdict per query
//
// One transaction is accepted per cycle while the result side does not stall; a query
// passes the input stage and then the lane pipeline: product, min/max, sum and sign, reduce.
// Loads write the plane registers at acceptance and give no result.
// arst_n clears the stage valid bits; plane contents are undefined until loaded.
// A stall on the result side freezes every stage together, so nothing is lost.
`timescale 1ns / 1ps
`include "frustum_culling_tester_macros.svh"

module frustum_culling_tester #(
	parameter int PLANE_COUNT = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             query_valid,
	output logic             query_ready,
	input  fct_pkg::query_t  query,
	output logic             result_valid,
	input  logic             result_ready,
	output fct_pkg::result_t result
);
	import fct_pkg::*;

	logic         adv, accept, is_query;
	plane_t       planes [PLANE_COUNT];
	corners_t     crn_in, crn_s1;
	logic         vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [2:0]   kind_s1, kind_s2, kind_s3, kind_s4;
	result_t      res_s5;
	plane_flags_t flags [PLANE_COUNT];
	logic         out_any, min_any;
	logic [1:0]   verdict;
	logic signed [CORNER_W-1:0] nx, ny, nz, fx, fy, fz;

	// The whole pipeline moves whenever the output slot is free or being drained.
	assign adv         = !vld_s5 || result_ready;
	assign query_ready = adv;
	assign accept      = query_valid && adv;
	assign is_query    = (query.cmd == CMD_POINT) || (query.cmd == CMD_SPHERE) ||
	                     (query.cmd == CMD_CUBE) || (query.cmd == CMD_BOX);

	fct_plane_store #(.PLANE_COUNT(PLANE_COUNT)) u_store (
		.clk   (clk),
		.we    (accept && (query.cmd == CMD_LOAD)),
		.idx   (query.plane_index),
		.wdata ('{a: query.coef_a, b: query.coef_b, c: query.coef_c, d: query.coef_d}),
		.planes(planes)
	);

	// Corner preparation: each axis gets a low and a high coordinate, so that the
	// eight corners of a plane reduce to one maximum and one minimum sum.
	always_comb begin
		nx = CORNER_W'(query.near_x);
		ny = CORNER_W'(query.near_y);
		nz = CORNER_W'(query.near_z);
		fx = CORNER_W'(query.far_x_or_extent);
		fy = CORNER_W'(query.far_y);
		fz = CORNER_W'(query.far_z);
		crn_in = '{x0: nx, x1: nx, y0: ny, y1: ny, z0: nz, z1: nz, radd: '0};
		case (query.cmd)
			CMD_SPHERE: begin
				crn_in.radd = query.far_x_or_extent;
			end
			CMD_CUBE: begin
				crn_in.x0 = nx - fx;
				crn_in.x1 = nx + fx;
				crn_in.y0 = ny - fx;
				crn_in.y1 = ny + fx;
				crn_in.z0 = nz - fx;
				crn_in.z1 = nz + fx;
			end
			CMD_BOX: begin
				crn_in.x1 = fx;
				crn_in.y1 = fy;
				crn_in.z1 = fz;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			crn_s1  <= crn_in;
			kind_s1 <= query.cmd;
			kind_s2 <= kind_s1;
			kind_s3 <= kind_s2;
			kind_s4 <= kind_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= accept && is_query;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_lane
		fct_plane_eval u_eval (
			.clk  (clk),
			.en   (adv),
			.plane(planes[p]),
			.crn  (crn_s1),
			.flags(flags[p])
		);
	end

	// Box queries are outside only when every corner is strictly below a plane;
	// the others count a corner on the plane as outside.
	always_comb begin
		out_any = 1'b0;
		min_any = 1'b0;
		for (int p = 0; p < PLANE_COUNT; p++) begin
			out_any = out_any || ((kind_s4 == CMD_BOX) ? flags[p].out_lt : flags[p].out_le);
			min_any = min_any || flags[p].min_lt;
		end
		if (out_any) begin
			verdict = V_OUTSIDE;
		end else if ((kind_s4 == CMD_BOX) && min_any) begin
			verdict = V_STRADDLE;
		end else begin
			verdict = V_INSIDE;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s5 <= '{verdict: verdict, query_kind: kind_s4};
		end
	end

	assign result_valid = vld_s5;
	assign result       = res_s5;

	`FCT_ASSERT_IMPL(a_intersect_box_only, clk, arst_n, result_valid, (result.verdict != V_STRADDLE) || (result.query_kind == CMD_BOX), "intersecting verdict on a non-box query")
	`FCT_ASSERT_NEXT(a_query_enters, clk, arst_n, accept && is_query, vld_s1 && (kind_s1 == $past(query.cmd)), "accepted query missing from first stage")
	`FCT_ASSERT_NEXT(a_load_no_result, clk, arst_n, accept && (query.cmd == CMD_LOAD), !vld_s1, "load transaction entered the query pipeline")
	`FCT_ASSERT_NEXT(a_stage_moves, clk, arst_n, vld_s4 && adv, vld_s5, "verdict lost between last stages")

endmodule
